// ===== hw/rtl/skf_pkg.sv =====
`default_nettype none

package skf_pkg;

  localparam int FRAC_BITS = 16;

  // field widths
  localparam int EST_W  = 32;
  localparam int COV_W  = 31;
  localparam int GAIN_W = 17;
  localparam int DEN_W  = COV_W + 1;
  localparam int CFG_W  = 32;

  // divider: quotient never exceeds 2^FRAC_BITS
  localparam int DIV_STEPS = FRAC_BITS + 1;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
  localparam int GQ_W      = DIV_STEPS;

  // shared multiplier operand widths
  localparam int MA_W = GQ_W + 1;
  localparam int MB_W = EST_W + 1;
  localparam int MP_W = MA_W + MB_W;

  localparam logic [COV_W-1:0] PROC_NOISE_RST = COV_W'(1180);
  localparam logic [COV_W-1:0] MEAS_NOISE_RST = COV_W'(35521);
  localparam logic [EST_W-1:0] START_EST_RST  = EST_W'(0);
  localparam logic [COV_W-1:0] START_COV_RST  = COV_W'(1311);

  typedef enum logic [1:0] {
    CFG_PROC_NOISE = 2'd0,
    CFG_MEAS_NOISE = 2'd1,
    CFG_START_EST  = 2'd2,
    CFG_START_COV  = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_DIV,
    ST_MUL_E,
    ST_MUL_C,
    ST_COV,
    ST_OUT
  } skf_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/skf_in_if.sv =====
`default_nettype none

interface skf_in_if import skf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [EST_W-1:0] measurement;

  modport source (output valid, output measurement, input ready);
  modport sink   (input valid, input measurement, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/skf_out_if.sv =====
`default_nettype none

interface skf_out_if import skf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [EST_W-1:0] estimate;
  logic [COV_W-1:0]        covariance;
  logic [GAIN_W-1:0]       gain;

  modport source (output valid, output estimate, output covariance, output gain, input ready);
  modport sink   (input valid, input estimate, input covariance, input gain, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/skf_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle: quot = floor(num * 2^FRAC_BITS / den).
// Requires num <= den, so the quotient fits in FRAC_BITS+1 bits.
module skf_div import skf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [COV_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [GQ_W-1:0]       quot
);

  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 first_r;
  logic                 done_r;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [DEN_W-1:0]     den_r;
  logic [GQ_W-1:0]      quot_r;
  logic [DEN_W:0]       trial;
  logic [DEN_W:0]       diff;
  logic                 ge;

  // first step compares the plain numerator (integer quotient bit)
  always_comb begin
    trial   = first_r ? {1'b0, rem_r} : {rem_r, 1'b0};
    diff    = trial - {1'b0, den_r};
    ge      = (trial >= {1'b0, den_r});
    rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      first_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r   <= DIV_CNT_W'(DIV_STEPS);
        first_r <= 1'b1;
      end else if (cnt_r != '0) begin
        cnt_r   <= cnt_r - DIV_CNT_W'(1);
        first_r <= 1'b0;
        done_r  <= (cnt_r == DIV_CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {1'b0, num};
      den_r  <= den;
      quot_r <= '0;
    end else if (cnt_r != '0) begin
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[GQ_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

`default_nettype wire

// ===== hw/rtl/scalar_kalman_filter.sv =====
`default_nettype none

// Channel  Dir  Payload                                 Handshake
// in_ch    in   measurement (s32 Q16.16)                valid/ready
// out_ch   out  estimate s32, covariance u31, gain u17  valid/ready
// cfg_*    in   cfg_idx 2b, cfg_wdata 32b               cfg_we, no wait
//
// From acceptance to out valid, a measurement's time goes mostly to the
// bit-serial divider forming the gain with FRAC_BITS fraction bits (16 at
// Q16.16); estimate and covariance then share one multiplier. in_ch.ready is
// high only when idle, so a result held by a stalled sink blocks the next
// transaction. Synchronous active-low reset restores register defaults and
// the initial estimate/covariance.
module scalar_kalman_filter import skf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  skf_in_if.sink                in_ch,
  skf_out_if.source             out_ch,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_idx,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam int CORR_W = MP_W - FRAC_BITS;
  localparam int EW     = CORR_W + 1;
  localparam int GX_W   = (GQ_W > GAIN_W) ? GQ_W : GAIN_W;
  localparam logic signed [MP_W-1:0] HALF  = MP_W'(1) <<< (FRAC_BITS - 1);
  localparam logic [GQ_W-1:0]        ONE_G = GQ_W'(1) << FRAC_BITS;
  localparam logic signed [EW-1:0]   EST_MAX = (EW'(1) <<< (EST_W - 1)) - EW'(1);
  localparam logic signed [EW-1:0]   EST_MIN = -(EW'(1) <<< (EST_W - 1));

  skf_state_t state_r, state_nxt;

  logic [COV_W-1:0]        pn_r, mn_r;
  logic signed [EST_W-1:0] est_r;
  logic [COV_W-1:0]        cov_r;
  logic [COV_W-1:0]        pm_r;
  logic signed [MB_W-1:0]  diff_r;
  logic                    den_zero_r;
  logic [GQ_W-1:0]         gain_r;
  logic signed [MP_W-1:0]  prod_r;
  logic signed [EST_W-1:0] out_est_r;
  logic [COV_W-1:0]        out_cov_r;
  logic [GAIN_W-1:0]       out_gain_r;

  logic                    in_acc;
  logic                    div_start, div_done;
  logic [GQ_W-1:0]         div_quot;
  logic [DEN_W-1:0]        den;
  logic [COV_W:0]          pred_sum;
  logic [COV_W-1:0]        pm;
  logic                    mul_en, mul_cov_sel, est_we, cov_we;
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [MP_W-1:0]  rnd;
  logic signed [CORR_W-1:0] corr;
  logic signed [EW-1:0]    est_wide;
  logic signed [EST_W-1:0] est_new;
  logic [COV_W-1:0]        cov_new;
  logic [GX_W-1:0]         gain_x;

  assign in_acc = in_ch.valid && in_ch.ready;

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_ch.valid) begin
        state_nxt = ST_PRED;
      end
      ST_PRED:  state_nxt = ST_DIV;
      ST_DIV:   if (div_done) begin
        state_nxt = ST_MUL_E;
      end
      ST_MUL_E: state_nxt = ST_MUL_C;
      ST_MUL_C: state_nxt = ST_COV;
      ST_COV:   state_nxt = ST_OUT;
      ST_OUT:   if (out_ch.ready) begin
        state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    div_start    = 1'b0;
    mul_en       = 1'b0;
    mul_cov_sel  = 1'b0;
    est_we       = 1'b0;
    cov_we       = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ch.ready = 1'b1;
      ST_PRED:  div_start = 1'b1;
      ST_DIV:   ;
      ST_MUL_E: mul_en = 1'b1;
      ST_MUL_C: begin
        mul_en      = 1'b1;
        mul_cov_sel = 1'b1;
        est_we      = 1'b1;
      end
      ST_COV:   cov_we = 1'b1;
      ST_OUT:   out_ch.valid = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- prediction and gain ----------------
  assign pred_sum = {1'b0, cov_r} + {1'b0, pn_r};
  assign pm       = pred_sum[COV_W] ? {COV_W{1'b1}} : pred_sum[COV_W-1:0];
  assign den      = {1'b0, pm_r} + {1'b0, mn_r};

  skf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (pm_r),
    .den   (den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pm_r   <= pm;
      diff_r <= MB_W'(in_ch.measurement) - MB_W'(est_r);
    end
    if (div_start) begin
      den_zero_r <= (den == '0);
    end
    if (state_r == ST_DIV && div_done) begin
      gain_r <= den_zero_r ? '0 : div_quot;
    end
  end

  // ---------------- shared multiplier ----------------
  always_comb begin
    if (mul_cov_sel) begin
      mul_a = signed'({1'b0, ONE_G - gain_r});
      mul_b = signed'({{(MB_W-COV_W){1'b0}}, pm_r});
    end else begin
      mul_a = signed'({1'b0, gain_r});
      mul_b = diff_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // round half up, floor shift
  assign rnd      = prod_r + HALF;
  assign corr     = rnd[MP_W-1:FRAC_BITS];
  assign est_wide = EW'(est_r) + EW'(corr);
  assign cov_new  = rnd[FRAC_BITS +: COV_W];
  assign gain_x   = GX_W'(gain_r);

  always_comb begin
    if (est_wide > EST_MAX) begin
      est_new = EST_MAX[EST_W-1:0];
    end else if (est_wide < EST_MIN) begin
      est_new = EST_MIN[EST_W-1:0];
    end else begin
      est_new = est_wide[EST_W-1:0];
    end
  end

  // ---------------- state and configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pn_r  <= PROC_NOISE_RST;
      mn_r  <= MEAS_NOISE_RST;
      est_r <= START_EST_RST;
      cov_r <= START_COV_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_idx))
          CFG_PROC_NOISE: pn_r  <= cfg_wdata[COV_W-1:0];
          CFG_MEAS_NOISE: mn_r  <= cfg_wdata[COV_W-1:0];
          CFG_START_EST:  est_r <= cfg_wdata[EST_W-1:0];
          CFG_START_COV:  cov_r <= cfg_wdata[COV_W-1:0];
          default:        ;
        endcase
      end
      if (est_we) begin
        est_r <= est_new;
      end
      if (cov_we) begin
        cov_r <= cov_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (est_we) begin
      out_est_r <= est_new;
    end
    if (cov_we) begin
      out_cov_r  <= cov_new;
      out_gain_r <= gain_x[GAIN_W-1:0];
    end
  end

  assign out_ch.estimate   = out_est_r;
  assign out_ch.covariance = out_cov_r;
  assign out_ch.gain       = out_gain_r;

  // ---------------- assertions ----------------
  a_acc_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_PRED)
    else $error("accepted transaction did not start prediction");

  a_cov_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.covariance <= pm_r)
    else $error("updated covariance exceeds prediction");

  a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL_E |-> gain_r <= ONE_G)
    else $error("gain above one");

  a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL_E && den_zero_r |-> gain_r == '0)
    else $error("nonzero gain with zero denominator");

endmodule

`default_nettype wire

// ===== sim/scalar_kalman_filter_test.sv =====
`timescale 1ns / 1ps

module scalar_kalman_filter_test;
  import skf_pkg::*;

  localparam int CYCLE_LIMIT      = 600_000;
  localparam int ITEM_LATENCY     = FRAC_BITS + 7;
  localparam int ITEMS_PER_MIX    = 384;
  localparam int SETTINGS_PER_MIX = 4;
  localparam int MAX_PRINTED      = 20;

  localparam longint unsigned COV_MAX = 64'h7fff_ffff;
  localparam longint unsigned UNITY   = 64'd1 << FRAC_BITS;
  localparam longint ROUND_HALF       = longint'(1) << (FRAC_BITS - 1);
  localparam longint EST_HI           = 64'sh7fff_ffff;
  localparam longint EST_LO           = -64'sh8000_0000;

  typedef struct {
    logic signed [EST_W-1:0] estimate;
    logic [COV_W-1:0]        covariance;
    logic [GAIN_W-1:0]       gain;
  } kalman_result_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  cfg_idx_t         cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;

  skf_in_if  in_ch ();
  skf_out_if out_ch ();

  scalar_kalman_filter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // filter state and registers as the block should hold them
  logic [COV_W-1:0]        proc_noise_q;
  logic [COV_W-1:0]        meas_noise_q;
  logic [COV_W-1:0]        cov_q;
  logic signed [EST_W-1:0] est_q;

  kalman_result_t expected_results[$];
  kalman_result_t oldest;

  int err_count      = 0;
  int checked_count  = 0;
  int sent_count     = 0;
  int settings_count = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int sink_stall_pct = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic kalman_result_t kalman_update(input logic signed [EST_W-1:0] meas);
    longint unsigned pred_cov;
    longint unsigned den;
    longint unsigned gain_v;
    longint unsigned cov_v;
    longint          diff;
    longint          corr;
    longint          est_v;
    kalman_result_t  r;
    pred_cov = 64'(cov_q) + 64'(proc_noise_q);
    if (pred_cov > COV_MAX) pred_cov = COV_MAX;
    den    = pred_cov + 64'(meas_noise_q);
    gain_v = (den == 0) ? 64'd0 : (pred_cov << FRAC_BITS) / den;
    if (gain_v > UNITY) gain_v = UNITY;
    diff  = longint'(meas) - longint'(est_q);
    // floor shift of the rounded product
    corr  = (longint'(gain_v) * diff + ROUND_HALF) >>> FRAC_BITS;
    est_v = longint'(est_q) + corr;
    if (est_v > EST_HI) est_v = EST_HI;
    if (est_v < EST_LO) est_v = EST_LO;
    cov_v = ((UNITY - gain_v) * pred_cov + (UNITY >> 1)) >> FRAC_BITS;
    if (cov_v > COV_MAX) cov_v = COV_MAX;
    est_q = est_v[EST_W-1:0];
    cov_q = cov_v[COV_W-1:0];
    r.estimate   = est_v[EST_W-1:0];
    r.covariance = cov_v[COV_W-1:0];
    r.gain       = gain_v[GAIN_W-1:0];
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] pick_noise();
    case ($urandom_range(5))
      0:       return '0;
      1:       return 32'hffff_ffff;  // top bit must be dropped
      2:       return $urandom_range(0, 4096);
      3:       return $urandom_range(0, 1 << 20);
      default: return $urandom;
    endcase
  endfunction

  // mostly samples scattered around a true level, some wild ones
  function automatic logic signed [EST_W-1:0] noisy_sample(input longint level);
    longint v;
    int     spread;
    int     pick;
    pick = $urandom_range(99);
    if (pick < 12) return $urandom;
    if (pick < 17) begin
      case ($urandom_range(3))
        0:       return 32'sh7fff_ffff;
        1:       return 32'sh8000_0000;
        2:       return '0;
        default: return '1;
      endcase
    end
    spread = $urandom_range(4, 30);
    v = level + longint'($urandom_range(0, 32'd2 << spread)) - (longint'(1) << spread);
    if (v > EST_HI) v = EST_HI;
    if (v < EST_LO) v = EST_LO;
    return v[EST_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTED)
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic write_cfg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = value;
    case (idx)
      CFG_PROC_NOISE: proc_noise_q = value[COV_W-1:0];
      CFG_MEAS_NOISE: meas_noise_q = value[COV_W-1:0];
      CFG_START_EST:  est_q        = value;
      CFG_START_COV:  cov_q        = value[COV_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_idle();
    in_ch.valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_settings(input logic [CFG_W-1:0] proc_noise,
                                input logic [CFG_W-1:0] meas_noise,
                                input logic [CFG_W-1:0] start_est,
                                input logic [CFG_W-1:0] start_cov);
    wait_idle();
    write_cfg(CFG_PROC_NOISE, proc_noise);
    write_cfg(CFG_MEAS_NOISE, meas_noise);
    write_cfg(CFG_START_EST, start_est);
    write_cfg(CFG_START_COV, start_cov);
    settings_count++;
  endtask

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_measurement(input logic signed [EST_W-1:0] value);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 2 * ITEM_LATENCY) : 0;
    if (gap != 0) in_ch.valid = 1'b0;
    repeat (gap) @(negedge clk);
    in_ch.valid       = 1'b1;
    in_ch.measurement = value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_results.push_back(kalman_update(value));
    sent_count++;
    @(negedge clk);
  endtask

  task automatic test_reset_defaults();
    send_measurement(32'sh0001_0000);
    send_measurement(-32'sh0001_0000);
    send_measurement(32'sh1234_5678);
  endtask

  task automatic test_measurement_extremes();
    send_measurement(32'sh7fff_ffff);
    send_measurement(32'sh8000_0000);
    send_measurement(32'sh7fff_ffff);
    send_measurement('0);
    send_measurement('1);
  endtask

  task automatic test_covariance_saturation();
    apply_settings(32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'h7fff_ffff);
    send_measurement(32'sh8000_0000);
    send_measurement(32'sh7fff_ffff);
    send_measurement(32'sh0000_0001);
  endtask

  task automatic test_zero_denominator();
    // no noise and no covariance: gain stays zero, estimate frozen
    apply_settings('0, '0, 32'h4000_0000, '0);
    send_measurement(32'sh8000_0000);
    send_measurement(32'sh7fff_ffff);
    send_measurement('0);
    // covariance but no measurement noise: full gain
    wait_idle();
    write_cfg(CFG_START_COV, 32'h0000_0100);
    send_measurement(-32'sh0123_4567);
    send_measurement(32'sh7654_3210);
  endtask

  task automatic test_noise_extremes();
    apply_settings('0, 32'hffff_ffff, 32'hc000_0000, 32'd1);
    send_measurement(32'sh7fff_ffff);
    send_measurement(32'sh3fff_ffff);
    // largest denominator the block can see
    apply_settings(32'hffff_ffff, 32'hffff_ffff, '0, 32'hffff_ffff);
    send_measurement(32'sh8000_0000);
    send_measurement(32'sh7fff_ffff);
  endtask

  task automatic test_traffic_mix(input int idle_pct, input int stall_pct);
    longint level;
    for (int s = 0; s < SETTINGS_PER_MIX; s++) begin
      apply_settings(pick_noise(), pick_noise(), $urandom, pick_noise());
      send_idle_pct  = idle_pct;
      sink_stall_pct = stall_pct;
      level = longint'($signed($urandom)) >>> $urandom_range(0, 16);
      for (int i = 0; i < ITEMS_PER_MIX / SETTINGS_PER_MIX; i++) begin
        if ($urandom_range(31) == 0)
          level = longint'($signed($urandom)) >>> $urandom_range(0, 16);
        send_measurement(noisy_sample(level));
      end
    end
  endtask

  always @(negedge clk) out_ch.ready = ($urandom_range(99) >= sink_stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        oldest = expected_results.pop_front();
        checked_count++;
        if (out_ch.estimate !== oldest.estimate)
          report_mismatch($sformatf("estimate got %0d expected %0d",
                                    out_ch.estimate, oldest.estimate));
        if (out_ch.covariance !== oldest.covariance)
          report_mismatch($sformatf("covariance got %0d expected %0d",
                                    out_ch.covariance, oldest.covariance));
        if (out_ch.gain !== oldest.gain)
          report_mismatch($sformatf("gain got %0d expected %0d",
                                    out_ch.gain, oldest.gain));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_PROC_NOISE;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.measurement = '0;
    out_ch.ready      = 1'b1;
    proc_noise_q      = PROC_NOISE_RST;
    meas_noise_q      = MEAS_NOISE_RST;
    est_q             = START_EST_RST;
    cov_q             = START_COV_RST;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_measurement_extremes();
    test_covariance_saturation();
    test_zero_denominator();
    test_noise_extremes();
    test_traffic_mix(0, 0);
    test_traffic_mix(64, 0);
    test_traffic_mix(0, 64);
    test_traffic_mix(12, 12);

    in_ch.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2 * ITEM_LATENCY) @(posedge clk);

    $display("filtered %0d measurements under %0d register settings, four traffic mixes",
             sent_count, settings_count);
    $display("%0d results compared, %0d mismatches", checked_count, err_count);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
